[rtl/drs_pkg.sv]
package drs_pkg;

    localparam int PROG_W    = 5;
    localparam int BEGIN_LEN = 29;
    localparam int END_LEN   = 30;

    localparam logic [7:0] FILL_BYTE = 8'h2B;
    localparam logic [7:0] TAG_OPEN  = 8'h3C;
    localparam logic [7:0] TAG_SLASH = 8'h2F;

    // Opening tag, one byte per entry; the closing tag is the same with a slash after '<'.
    localparam logic [7:0] BEGIN_TAG [BEGIN_LEN] = '{
        8'h3C, 8'h70, 8'h68, 8'h6F, 8'h74, 8'h6F, 8'h73, 8'h68, 8'h6F, 8'h70, 8'h3A,
        8'h44, 8'h6F, 8'h63, 8'h75, 8'h6D, 8'h65, 8'h6E, 8'h74,
        8'h41, 8'h6E, 8'h63, 8'h65, 8'h73, 8'h74, 8'h6F, 8'h72, 8'h73, 8'h3E
    };

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } t_cell_beat;

    typedef struct packed {
        logic shift;
        logic scrub;
    } t_cell_ctrl;

    function automatic logic [7:0] begin_byte(input logic [PROG_W-1:0] idx);
        logic [7:0] res;
        res = 8'h00;
        if (idx < PROG_W'(BEGIN_LEN)) begin
            res = BEGIN_TAG[idx];
        end
        return res;
    endfunction

    function automatic logic [7:0] end_byte(input logic [PROG_W-1:0] idx);
        logic [7:0] res;
        if (idx == '0) begin
            res = TAG_OPEN;
        end else if (idx == PROG_W'(1)) begin
            res = TAG_SLASH;
        end else begin
            res = begin_byte(idx - PROG_W'(1));
        end
        return res;
    endfunction

    // Step a tag match counter by one byte. The opening '<' appears only at the
    // head of either tag, so a mismatch restarts at one on '<' and at zero otherwise.
    function automatic logic [PROG_W-1:0] tag_advance(
        input logic [PROG_W-1:0] prog,
        input logic [7:0]        b,
        input logic              is_end
    );
        logic [7:0]        want;
        logic              in_range;
        logic [PROG_W-1:0] res;
        want     = is_end ? end_byte(prog) : begin_byte(prog);
        in_range = is_end ? (prog < PROG_W'(END_LEN)) : (prog < PROG_W'(BEGIN_LEN));
        if (in_range && (want == b)) begin
            res = prog + PROG_W'(1);
        end else if (b == TAG_OPEN) begin
            res = PROG_W'(1);
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

[rtl/drs_in_if.sv]
interface drs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/drs_out_if.sv]
interface drs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[rtl/drs_cell.sv]
module drs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drs_pkg::t_cell_ctrl i_ctrl,
    input  drs_pkg::t_cell_beat i_beat,
    output drs_pkg::t_cell_beat o_beat
);
    import drs_pkg::*;

    logic       r_valid;
    logic       r_last;
    logic [7:0] r_data;

    // Scrub overwrites the byte on its way to the neighbor.
    assign o_beat.valid = r_valid;
    assign o_beat.last  = r_last;
    assign o_beat.data  = i_ctrl.scrub ? FILL_BYTE : r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_beat.valid;
            r_last  <= i_beat.last;
        end
        if (i_ctrl.shift) begin
            r_data <= i_beat.data;
        end
    end

endmodule

[rtl/drs_matcher.sv]
module drs_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic [7:0] o_byte,
    output logic       o_scrub
);
    import drs_pkg::*;

    logic              r_in_region;
    logic [PROG_W-1:0] r_begin_prog;
    logic [PROG_W-1:0] r_end_prog;
    logic              n_in_region;
    logic [PROG_W-1:0] n_begin_prog;
    logic [PROG_W-1:0] n_end_prog;
    logic [PROG_W-1:0] w_begin_adv;
    logic [PROG_W-1:0] w_end_adv;

    assign w_begin_adv = tag_advance(r_begin_prog, i_data_byte, 1'b0);
    assign w_end_adv   = tag_advance(r_end_prog, i_data_byte, 1'b1);

    always_comb begin
        n_in_region  = r_in_region;
        n_begin_prog = r_begin_prog;
        n_end_prog   = r_end_prog;
        o_byte       = i_data_byte;
        o_scrub      = 1'b0;
        if (!r_in_region) begin
            if (w_begin_adv == PROG_W'(BEGIN_LEN)) begin
                // Opening tag complete: scrub everything held and enter the region.
                o_byte       = FILL_BYTE;
                o_scrub      = 1'b1;
                n_in_region  = 1'b1;
                n_begin_prog = '0;
                n_end_prog   = '0;
            end else begin
                n_begin_prog = w_begin_adv;
            end
        end else begin
            o_byte = FILL_BYTE;
            if (w_end_adv == PROG_W'(END_LEN)) begin
                n_in_region  = 1'b0;
                n_begin_prog = '0;
                n_end_prog   = '0;
            end else begin
                n_end_prog = w_end_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_region  <= 1'b0;
            r_begin_prog <= '0;
            r_end_prog   <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_in_region  <= 1'b0;
                r_begin_prog <= '0;
                r_end_prog   <= '0;
            end else begin
                r_in_region  <= n_in_region;
                r_begin_prog <= n_begin_prog;
                r_end_prog   <= n_end_prog;
            end
        end
    end

endmodule

[rtl/delimited_region_scrubber_core.sv]
// Region scrubber for a byte stream.
// i_in carries one byte per beat (data_byte, last_byte marks the end of a stream).
// o_out carries one byte per beat (out_byte, out_last set on the final byte).
// Every span from the opening tag through the next closing tag, both tags
// included, comes out as '+'; a span left open is scrubbed to the end of the
// stream, and a closing tag with no opening tag passes unchanged.
// Throughput: one input beat per cycle while i_in.ready is high. A chain of
// DELAY_DEPTH cells holds the newest bytes, so a byte leaves only when DELAY_DEPTH
// later bytes, or empty slots while draining, have entered. On a beat with
// last_byte set, the chain drains: the held bytes and the final byte follow on
// o_out, and i_in.ready stays low until the final byte has left the chain.
// A stall on o_out holds the output register and freezes the chain only when
// its oldest cell has a byte to hand over; otherwise input keeps flowing.
// Reset (synchronous, active low) empties the chain and clears match state.
module delimited_region_scrubber_core #(
    parameter int DELAY_DEPTH = 28
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    drs_in_if.sink           i_in,
    drs_out_if.source        o_out
);
    import drs_pkg::*;

    t_cell_beat w_beat [DELAY_DEPTH+1];
    t_cell_ctrl w_ctrl;
    t_cell_beat w_tail;

    logic       w_out_free;
    logic       w_shift_ok;
    logic       w_accept;
    logic [7:0] w_store_byte;
    logic       w_scrub;

    logic       r_flush;
    logic       r_out_valid;
    logic       r_out_last;
    logic [7:0] r_out_byte;

    // Match the tags on the incoming byte.
    drs_matcher u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_byte      (w_store_byte),
        .o_scrub     (w_scrub)
    );

    assign w_tail     = w_beat[DELAY_DEPTH];
    // Advance the chain only if the oldest byte has somewhere to go.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_shift_ok = !w_tail.valid || w_out_free;
    assign i_in.ready = !r_flush && w_shift_ok;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_ctrl.shift = w_accept || (r_flush && w_shift_ok);
    assign w_ctrl.scrub = w_accept && w_scrub;

    // Head of the chain: the new byte, or an empty slot while draining.
    assign w_beat[0].valid = w_accept;
    assign w_beat[0].last  = w_accept && i_in.last_byte;
    assign w_beat[0].data  = w_store_byte;

    for (genvar k = 0; k < DELAY_DEPTH; k++) begin : g_cell
        drs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_beat  (w_beat[k]),
            .o_beat  (w_beat[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            // Drain after the final byte until it leaves the chain.
            if (w_accept && i_in.last_byte) begin
                r_flush <= 1'b1;
            end else if (w_ctrl.shift && w_tail.valid && w_tail.last) begin
                r_flush <= 1'b0;
            end
            if (w_ctrl.shift && w_tail.valid) begin
                r_out_valid <= 1'b1;
                r_out_last  <= w_tail.last;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_ctrl.shift && w_tail.valid) begin
            r_out_byte <= w_tail.data;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;

`ifndef ASSERT_OFF
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !i_in.ready)
        else $error("input taken while draining");

    a_last_starts_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.last_byte) |=> r_flush)
        else $error("final byte did not start drain");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.shift && w_tail.valid) |-> w_out_free)
        else $error("pending output overwritten");
`endif

endmodule
